// File: hw/rtl/bscp_pkg.sv
// shared types and constants of the battery charge plausibility check
// holds the voltage-to-charge curve, per-segment slope and tolerance tables
// no dependencies
package bscp_pkg;

  // curve storage
  localparam int unsigned TABLE_LEN = 8;
  localparam int unsigned SEG_W     = $clog2(TABLE_LEN);
  localparam int unsigned MV_W      = 13;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned TOL_W     = 5;
  localparam int unsigned MPCT_W    = 17;  // milli-percent, 0..100000
  localparam int unsigned SLOPE_W   = 10;  // milli-percent per millivolt

  // descending curve, voltage in mV and charge in milli-percent
  localparam logic [MV_W-1:0] CURVE_MV [TABLE_LEN] = '{
    13'd4100, 13'd3893, 13'd3783, 13'd3721, 13'd3686, 13'd3575, 13'd3487, 13'd3300
  };
  localparam logic [MPCT_W-1:0] CURVE_MPCT [TABLE_LEN] = '{
    17'd100000, 17'd75000, 17'd57000, 17'd36000, 17'd20000, 17'd4000, 17'd2000, 17'd0
  };

  // segment k runs from point k-1 down to point k; entry zero is unused
  // slope is the truncated charge step over voltage step of the segment
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [TABLE_LEN] = '{
    10'd0, 10'd120, 10'd163, 10'd338, 10'd457, 10'd144, 10'd22, 10'd10
  };
  // truncated slope*53/1000 held between a floor of five and a ceiling of 31
  localparam logic [TOL_W-1:0] SEG_TOL [TABLE_LEN] = '{
    5'd5, 5'd6, 5'd8, 5'd17, 5'd24, 5'd7, 5'd5, 5'd5
  };

  typedef struct packed {
    logic [MV_W-1:0]  voltage_mv;
    logic [PCT_W-1:0] reported_percent;
  } bscp_in_t;

  typedef struct packed {
    logic             plausible;
    logic [PCT_W-1:0] expected_percent;
    logic [TOL_W-1:0] tolerance_percent;
  } bscp_out_t;

  // segment search: the curve falls, so the voltage lies below every point
  // up to some index; the last passing compare gives the segment
  function automatic logic [SEG_W-1:0] find_segment(
    input logic [MV_W-1:0]  volt,
    input logic [SEG_W-1:0] last_seg
  );
    logic [SEG_W-1:0] seg;
    seg = SEG_W'(1);
    for (int k = 1; k < TABLE_LEN - 1; k++) begin
      if ((SEG_W'(k) < last_seg) && (volt < CURVE_MV[k])) begin
        seg = SEG_W'(k + 1);
      end
    end
    return seg;
  endfunction

endpackage

// File: hw/rtl/battery_soc_plausibility_check.sv
// top level of the battery charge plausibility check
// depends on bscp_pkg, bscp_interp and bscp_div_milli
//
// Checks a gauge's reported charge against the charge expected from the cell
// voltage on a fixed eight-point discharge curve. Each transfer on the input
// channel yields exactly one transfer on the output channel, in order. The
// block is a three-stage pipeline: segment search, interpolation with clamp,
// then division to whole percent and the tolerance compare. A new item can be
// taken every cycle, so the sustained rate is one item per clock. Each stage
// holds while the stage after it is full and stalled, so throughput drops
// only when the consumer withholds out_ready_i. There is no configuration
// and no state beyond the pipeline valid bits. CURVE_POINTS selects how many
// curve points are used (values above eight act as eight, below two as two).
module battery_soc_plausibility_check #(
  parameter int unsigned CURVE_POINTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bscp_pkg::bscp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bscp_pkg::bscp_out_t out_data_o
);
  import bscp_pkg::*;

  // number of points actually used, and the index of the last segment
  localparam int unsigned NUM_PTS  = (CURVE_POINTS > TABLE_LEN) ? TABLE_LEN :
                                     (CURVE_POINTS < 2) ? 2 : CURVE_POINTS;
  localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(NUM_PTS - 1);

  // stage one: segment index alongside the raw input
  logic             s1_valid_q;
  logic [SEG_W-1:0] s1_seg_q;
  logic [MV_W-1:0]  s1_volt_q;
  logic [PCT_W-1:0] s1_cap_q;

  // stage two: clamped charge in milli-percent and the segment tolerance
  logic              s2_valid_q;
  logic [MPCT_W-1:0] s2_mpct_q;
  logic [TOL_W-1:0]  s2_tol_q;
  logic [PCT_W-1:0]  s2_cap_q;

  // output register
  logic      out_valid_q;
  bscp_out_t out_data_q;
  bscp_out_t out_data_d;

  logic              out_take;
  logic              s2_take;
  logic              s1_take;
  logic [MPCT_W-1:0] s2_mpct_d;
  logic [TOL_W-1:0]  s2_tol_d;
  logic [PCT_W-1:0]  expected;
  logic [PCT_W:0]    upper;
  logic [PCT_W:0]    cap_plus_tol;

  // a stage loads when it is empty or its contents move on this cycle
  assign out_take   = !out_valid_q || out_ready_i;
  assign s2_take    = !s2_valid_q || out_take;
  assign s1_take    = !s1_valid_q || s2_take;
  assign in_ready_o = s1_take;

  // ---- stage one: segment search straight from the input transfer ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_take) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && in_valid_i) begin
      s1_seg_q  <= find_segment(in_data_i.voltage_mv, LAST_SEG);
      s1_volt_q <= in_data_i.voltage_mv;
      s1_cap_q  <= in_data_i.reported_percent;
    end
  end

  // ---- stage two: slope multiply, offset and clamp ----
  bscp_interp u_interp (
    .seg_i         (s1_seg_q),
    .voltage_i     (s1_volt_q),
    .charge_mpct_o (s2_mpct_d),
    .tol_o         (s2_tol_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_take) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take && s1_valid_q) begin
      s2_mpct_q <= s2_mpct_d;
      s2_tol_q  <= s2_tol_d;
      s2_cap_q  <= s1_cap_q;
    end
  end

  // ---- stage three: whole percent and the strict window compare ----
  bscp_div_milli u_div (
    .mpct_i (s2_mpct_q),
    .pct_o  (expected)
  );

  // reported < expected + tol and reported + tol > expected, kept unsigned
  assign upper        = {1'b0, expected} + (PCT_W + 1)'(s2_tol_q);
  assign cap_plus_tol = {1'b0, s2_cap_q} + (PCT_W + 1)'(s2_tol_q);

  always_comb begin
    out_data_d.plausible         = ({1'b0, s2_cap_q} < upper) &&
                                   (cap_plus_tol > {1'b0, expected});
    out_data_d.expected_percent  = expected;
    out_data_d.tolerance_percent = s2_tol_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && s2_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hw/rtl/bscp_interp.sv
// linear interpolation on one curve segment with clamp to its end points
// depends on bscp_pkg for the curve and slope tables
module bscp_interp (
  input  logic [bscp_pkg::SEG_W-1:0]  seg_i,
  input  logic [bscp_pkg::MV_W-1:0]   voltage_i,
  output logic [bscp_pkg::MPCT_W-1:0] charge_mpct_o,
  output logic [bscp_pkg::TOL_W-1:0]  tol_o
);
  import bscp_pkg::*;

  localparam int unsigned DIFF_W = MV_W + 1;
  localparam int unsigned PROD_W = DIFF_W + SLOPE_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 1;

  logic [SEG_W-1:0]         seg_hi;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  y;
  logic signed [SUM_W-1:0]  lo_s;
  logic signed [SUM_W-1:0]  hi_s;

  assign seg_hi = seg_i - SEG_W'(1);
  assign diff   = $signed({1'b0, voltage_i}) - $signed({1'b0, CURVE_MV[seg_i]});
  assign prod   = PROD_W'(diff) * $signed({1'b0, SEG_SLOPE[seg_i]});
  assign lo_s   = $signed(SUM_W'(CURVE_MPCT[seg_i]));
  assign hi_s   = $signed(SUM_W'(CURVE_MPCT[seg_hi]));
  assign y      = lo_s + SUM_W'(prod);

  always_comb begin
    if (y > hi_s) begin
      charge_mpct_o = CURVE_MPCT[seg_hi];
    end else if (y < lo_s) begin
      charge_mpct_o = CURVE_MPCT[seg_i];
    end else begin
      charge_mpct_o = y[MPCT_W-1:0];
    end
  end

  assign tol_o = SEG_TOL[seg_i];

endmodule

// File: hw/rtl/bscp_div_milli.sv
// truncating division of a milli-percent value by 1000
// reciprocal multiply with one correction step; depends on bscp_pkg
module bscp_div_milli (
  input  logic [bscp_pkg::MPCT_W-1:0] mpct_i,
  output logic [bscp_pkg::PCT_W-1:0]  pct_o
);
  import bscp_pkg::*;

  // 1049 / 2^20 sits just above 1/1000, so the estimate is exact or one high
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 11;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(1049);
  localparam int unsigned PROD_W = MPCT_W + RECIP_W;
  localparam int unsigned REM_W  = MPCT_W + 1;

  logic [PROD_W-1:0]       prod;
  logic [PCT_W-1:0]        q_est;
  logic signed [REM_W-1:0] rem;

  assign prod  = PROD_W'(mpct_i) * PROD_W'(RECIP);
  assign q_est = prod[RECIP_SHIFT +: PCT_W];
  assign rem   = $signed({1'b0, mpct_i}) - $signed(REM_W'(q_est) * REM_W'(1000));
  assign pct_o = (rem < 0) ? (q_est - PCT_W'(1)) : q_est;

endmodule

// File: dv/battery_soc_plausibility_check_tb.sv
// testbench of the battery charge plausibility check, drives readings and checks each verdict
// depends on bscp_pkg and battery_soc_plausibility_check; needs nothing else
module battery_soc_plausibility_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bscp_pkg::*;

  // own copy of the discharge curve, voltage in mV and charge in milli-percent
  localparam int CURVE_N       = 8;
  localparam int LEAN_PCT      = 53;
  localparam int MILLI_PER_PCT = 1000;
  localparam int TOL_MIN       = 5;
  localparam int TOL_CEIL      = 31;
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 8;

  int curve_mv   [CURVE_N] = '{4100, 3893, 3783, 3721, 3686, 3575, 3487, 3300};
  int curve_mpct [CURVE_N] = '{100000, 75000, 57000, 36000, 20000, 4000, 2000, 0};

  logic      clk_i;
  logic      rst_ni     = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_ready;
  bscp_in_t  in_data    = '0;
  logic      out_valid;
  logic      out_ready  = 1'b0;
  bscp_out_t out_data;

  // transfers seen at the falling edge, taken at the following rising edge
  logic      in_xfer_seen  = 1'b0;
  logic      out_xfer_seen = 1'b0;
  bscp_out_t out_seen      = '0;

  bscp_out_t pending_verdicts [$];
  int        failures   = 0;
  bit        idling_on  = 1'b1;
  int        idle_count = 0;
  int        stall_left = 0;

  battery_soc_plausibility_check dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // expected verdict for one reading, integer arithmetic as the curve defines it
  function automatic bscp_out_t predict_verdict(bscp_in_t rd);
    longint    volt, cap, dx, dy, slope, y, hi, lo, pct, tol;
    int        seg;
    bscp_out_t res;
    volt = longint'(rd.voltage_mv);
    cap  = longint'(rd.reported_percent);
    seg  = 1;
    // falling curve: step down while the voltage is below the segment's lower point
    while (seg < CURVE_N - 1 && volt < curve_mv[seg]) seg++;
    dx    = curve_mv[seg-1] - curve_mv[seg];
    dy    = curve_mpct[seg-1] - curve_mpct[seg];
    // a flat segment would give no slope at all
    slope = (dx != 0) ? dy / dx : 0;
    y     = curve_mpct[seg] + (volt - curve_mv[seg]) * slope;
    hi    = curve_mpct[seg-1];
    lo    = curve_mpct[seg];
    if (lo > hi) begin
      longint t;
      t  = lo;
      lo = hi;
      hi = t;
    end
    // clamp pins voltages beyond either end of the curve to full or empty
    if (y > hi) y = hi;
    if (y < lo) y = lo;
    pct = y / MILLI_PER_PCT;
    if (pct < 0) pct = 0;
    if (pct > 100) pct = 100;
    tol = slope * LEAN_PCT / MILLI_PER_PCT;
    if (tol < 0) tol = -tol;
    if (tol < TOL_MIN) tol = TOL_MIN;
    if (tol > TOL_CEIL) tol = TOL_CEIL;
    // strict window on both sides; reported values above 100 compared as they are
    res.plausible         = (cap < pct + tol) && (cap > pct - tol);
    res.expected_percent  = PCT_W'(pct);
    res.tolerance_percent = TOL_W'(tol);
    return res;
  endfunction

  function automatic bscp_in_t make_reading(int volt, int cap);
    bscp_in_t rd;
    rd.voltage_mv       = MV_W'(volt);
    rd.reported_percent = PCT_W'(cap);
    return rd;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    failures++;
  endtask

  // one input transfer; entered and left at a rising edge
  task automatic send_reading(bscp_in_t rd);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= rd;
    do @(posedge clk_i); while (!in_xfer_seen);
    pending_verdicts.push_back(predict_verdict(rd));
  endtask

  // hold the sender until every outstanding verdict has come back
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  // reported charge near the expected one, so both verdicts turn up often
  function automatic int near_charge(int volt);
    bscp_out_t p;
    int        span, cap;
    p    = predict_verdict(make_reading(volt, 0));
    span = int'(p.tolerance_percent) + 3;
    cap  = int'(p.expected_percent) + int'($urandom_range(0, 2 * span)) - span;
    if (cap < 0) cap = 0;
    if (cap > 127) cap = 127;
    return cap;
  endfunction

  // voltage on or around the curve, now and then right at a curve point
  function automatic int curve_voltage();
    if ($urandom_range(0, 9) == 0) begin
      return curve_mv[$urandom_range(0, CURVE_N - 1)] + int'($urandom_range(0, 4)) - 2;
    end
    return int'($urandom_range(3250, 4150));
  endfunction

  // each curve point, and both ends of the voltage and charge fields
  task automatic test_curve_points();
    for (int k = 0; k < CURVE_N; k++) begin
      send_reading(make_reading(curve_mv[k], curve_mpct[k] / MILLI_PER_PCT));
    end
    send_reading(make_reading(0, 0));
    send_reading(make_reading(5119, 127));
    send_reading(make_reading(8191, 127));
    send_reading(make_reading(4101, 100));
    send_reading(make_reading(3299, 0));
  endtask

  // reported charge exactly on and just inside the tolerance edges
  task automatic test_tolerance_edges();
    int        probe [3] = '{3700, 3800, 3530};
    bscp_out_t p;
    int        e, t;
    foreach (probe[j]) begin
      p = predict_verdict(make_reading(probe[j], 0));
      e = int'(p.expected_percent);
      t = int'(p.tolerance_percent);
      send_reading(make_reading(probe[j], e + t));
      send_reading(make_reading(probe[j], e + t - 1));
      send_reading(make_reading(probe[j], (e - t < 0) ? 0 : e - t));
      send_reading(make_reading(probe[j], (e - t + 1 < 0) ? 0 : e - t + 1));
    end
  endtask

  task automatic test_random_curve(int count);
    int volt;
    repeat (count) begin
      volt = curve_voltage();
      send_reading(make_reading(volt, near_charge(volt)));
    end
  endtask

  // sender stops now and then until the pipeline is empty
  task automatic test_drain_pause(int count);
    int volt;
    for (int n = 0; n < count; n++) begin
      volt = curve_voltage();
      send_reading(make_reading(volt, near_charge(volt)));
      if (n % 25 == 24) drain_verdicts();
    end
  endtask

  // anything the fields can carry, out-of-range voltages and charges included
  task automatic test_random_noise(int count);
    int volt;
    repeat (count) begin
      volt = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8191))
                                         : int'($urandom_range(0, 5119));
      send_reading(make_reading(volt, int'($urandom_range(0, 127))));
    end
  endtask

  // back to back at full rate, no gaps and no stalls
  task automatic test_full_rate(int count);
    idling_on = 1'b0;
    test_random_curve(count);
  endtask

  // sampling half a cycle away from the driving edge keeps clear of races
  always @(negedge clk_i) begin
    in_xfer_seen  = in_valid && in_ready;
    out_xfer_seen = out_valid && out_ready;
    out_seen      = out_data;
  end

  // receiver readiness with random stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= rst_ni;
        if (idling_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
      end
    end
  end

  // verdict check against the oldest outstanding prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_xfer_seen) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected output transfer", 1, 0);
      end else begin
        bscp_out_t want;
        want = pending_verdicts.pop_front();
        if (out_seen.plausible !== want.plausible)
          report_mismatch("plausible", out_seen.plausible, want.plausible);
        if (out_seen.expected_percent !== want.expected_percent)
          report_mismatch("expected_percent", out_seen.expected_percent,
                          want.expected_percent);
        if (out_seen.tolerance_percent !== want.tolerance_percent)
          report_mismatch("tolerance_percent", out_seen.tolerance_percent,
                          want.tolerance_percent);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    forever begin
      @(posedge clk_i);
      if (in_xfer_seen || out_xfer_seen) idle_count = 0;
      else idle_count++;
      if (idle_count >= STALL_LIMIT) begin
        $display("watchdog expired at %0t", $realtime);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_curve_points();
    test_tolerance_edges();
    test_random_curve(900);
    test_drain_pause(100);
    test_random_noise(150);
    test_full_rate(150);

    // wait for the last verdicts, then a few cycles for anything stray
    drain_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
